@@ rtl/content_length_header_deframer_top_defines.svh @@
// ----------------------------------------------------------------------------
// content-length deframer assertion macros
// concurrent checks, removed when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CONTENT_LENGTH_HEADER_DEFRAMER_TOP_DEFINES_SVH
`define CONTENT_LENGTH_HEADER_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// check outside reset
`define CLD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check at every edge, reset included
`define CLD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLD_ASSERT(label, prop, msg)
`define CLD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/cld_pkg.sv @@
// ----------------------------------------------------------------------------
// cld_pkg
// shared constants, types and the header name table of the deframer
// ----------------------------------------------------------------------------
package cld_pkg;

  localparam int LENGTH_BITS = 32;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // length of the text "content-length:"
  localparam logic [3:0] NAME_LEN = 4'd15;

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [1:0] {
    STAT_BODY      = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NO_LENGTH = 2'd2
  } status_t;

  // per-line parse state
  typedef enum logic [3:0] {
    PH_NAME  = 4'b0001,
    PH_BLANK = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_REST  = 4'b1000
  } phase_t;

  // lower-case header name, one character per position
  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6f; // o
      4'd2:    ch = 8'h6e; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6e; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2d; // -
      4'd8:    ch = 8'h6c; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6e; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      4'd14:   ch = 8'h3a; // :
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/cld_in_if.sv @@
// ----------------------------------------------------------------------------
// cld_in_if
// raw byte channel into the deframer, valid/ready handshake
// ----------------------------------------------------------------------------
interface cld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ rtl/cld_out_if.sv @@
// ----------------------------------------------------------------------------
// cld_out_if
// result channel out of the deframer, valid/ready handshake
// ----------------------------------------------------------------------------
interface cld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic [1:0] status;
  logic       last_of_message;

  modport source (output valid, output body_byte, output status,
                  output last_of_message, input ready);
  modport sink   (input valid, input body_byte, input status,
                  input last_of_message, output ready);
endinterface

@@ rtl/content_length_header_deframer_top.sv @@
// latency: a result is valid the cycle after the input transaction that caused it
// throughput: one byte per cycle; a new byte is taken while a result is held,
//   as long as the result is taken in the same cycle or the result register is empty
// the per-byte update (name match, multiply by ten, saturate) is one register stage
// reset: synchronous, active low; parser returns to header search, result register empties
// ----------------------------------------------------------------------------
// content_length_header_deframer_top
// splits a byte stream into message bodies framed by content-length headers
// ----------------------------------------------------------------------------
`include "content_length_header_deframer_top_defines.svh"

module content_length_header_deframer_top
  import cld_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  cld_in_if.sink    in_ch,
  cld_out_if.source out_ch
);

  // parser state
  logic                   in_body_r,  in_body_nxt;
  phase_t                 phase_r,    phase_nxt;
  logic [3:0]             prefix_r,   prefix_nxt;
  logic                   has_chars_r, has_chars_nxt;
  logic                   cr_held_r,  cr_held_nxt;
  logic                   seen_r,     seen_nxt;
  logic [LENGTH_BITS-1:0] length_r,   length_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             body_r,      body_nxt;
  status_t                status_r,    status_nxt;
  logic                   last_r,      last_nxt;

  logic                   in_ready;
  logic                   in_fire;
  logic [7:0]             b;
  logic [7:0]             lc;
  logic                   is_digit;
  logic [3:0]             digit_val;
  logic [3:0]             prefix_inc;
  logic [LENGTH_BITS+3:0] length_ext;
  logic [LENGTH_BITS+3:0] length_x10;
  logic [LENGTH_BITS-1:0] length_add;
  logic [LENGTH_BITS-1:0] length_dec;
  logic                   lf_done;

  // result register empties or drains this cycle: room for one more transaction
  assign in_ready = !out_valid_r || out_ch.ready;
  assign in_fire  = in_ch.valid && in_ready;
  assign b        = in_ch.in_byte;

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_r;
  assign out_ch.body_byte       = body_r;
  assign out_ch.status          = status_r;
  assign out_ch.last_of_message = last_r;

  // character classes
  assign lc         = (b inside {[8'h41:8'h5a]}) ? (b + 8'h20) : b;
  assign is_digit   = (b inside {[CH_ZERO:CH_NINE]});
  assign digit_val  = 4'(b - CH_ZERO);
  assign prefix_inc = prefix_r + 4'd1;

  // length * 10 + digit as shift-add, four guard bits to spot overflow
  assign length_ext = {4'b0000, length_r};
  assign length_x10 = (length_ext << 3) + (length_ext << 1)
                      + {{LENGTH_BITS{1'b0}}, digit_val};
  assign length_add = (length_x10 > {4'b0000, LEN_MAX}) ? LEN_MAX
                                                        : length_x10[LENGTH_BITS-1:0];

  assign length_dec = (length_r != '0) ? (length_r - LENGTH_BITS'(1)) : length_r;

  always_comb begin
    in_body_nxt   = in_body_r;
    phase_nxt     = phase_r;
    prefix_nxt    = prefix_r;
    has_chars_nxt = has_chars_r;
    cr_held_nxt   = cr_held_r;
    seen_nxt      = seen_r;
    length_nxt    = length_r;
    lf_done       = 1'b0;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    body_nxt      = body_r;
    status_nxt    = status_r;
    last_nxt      = last_r;

    if (in_fire) begin
      if (in_body_r) begin
        // body byte passes straight through
        length_nxt    = length_dec;
        out_valid_nxt = 1'b1;
        body_nxt      = b;
        status_nxt    = STAT_BODY;
        last_nxt      = (length_dec == '0);
        if (length_dec == '0) begin
          in_body_nxt   = 1'b0;
          phase_nxt     = PH_NAME;
          prefix_nxt    = 4'd0;
          has_chars_nxt = 1'b0;
          cr_held_nxt   = 1'b0;
          seen_nxt      = 1'b0;
          length_nxt    = '0;
        end
      end else begin
        if (cr_held_r) begin
          cr_held_nxt = 1'b0;
          if (b == CH_LF) begin
            lf_done       = 1'b1;
            phase_nxt     = PH_NAME;
            prefix_nxt    = 4'd0;
            has_chars_nxt = 1'b0;
            if (!has_chars_r) begin
              // blank line closes the header block
              if (!seen_r) begin
                seen_nxt      = 1'b0;
                length_nxt    = '0;
                out_valid_nxt = 1'b1;
                body_nxt      = 8'h00;
                status_nxt    = STAT_NO_LENGTH;
                last_nxt      = 1'b0;
              end else if (length_r == '0) begin
                seen_nxt      = 1'b0;
                out_valid_nxt = 1'b1;
                body_nxt      = 8'h00;
                status_nxt    = STAT_EMPTY;
                last_nxt      = 1'b1;
              end else begin
                in_body_nxt = 1'b1;
              end
            end
          end else begin
            // bare carriage return is a line character; never a name or digit char
            has_chars_nxt = 1'b1;
            phase_nxt     = PH_REST;
          end
        end

        if (!lf_done) begin
          if (b == CH_CR) begin
            cr_held_nxt = 1'b1;
          end else begin
            has_chars_nxt = 1'b1;
            case (phase_nxt)
              PH_NAME: begin
                if (prefix_r < NAME_LEN && lc == name_char(prefix_r)) begin
                  prefix_nxt = prefix_inc;
                  if (prefix_inc == NAME_LEN) begin
                    phase_nxt  = PH_BLANK;
                    seen_nxt   = 1'b1;
                    length_nxt = '0;
                  end
                end else begin
                  phase_nxt = PH_REST;
                end
              end
              PH_BLANK: begin
                if (b == CH_SP || b == CH_TAB) begin
                  phase_nxt = PH_BLANK;
                end else if (is_digit) begin
                  phase_nxt  = PH_DIGIT;
                  length_nxt = length_add;
                end else begin
                  phase_nxt = PH_REST;
                end
              end
              PH_DIGIT: begin
                if (is_digit) begin
                  length_nxt = length_add;
                end else begin
                  phase_nxt = PH_REST;
                end
              end
              default: begin
                phase_nxt = PH_REST;
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_body_r   <= 1'b0;
      phase_r     <= PH_NAME;
      prefix_r    <= 4'd0;
      has_chars_r <= 1'b0;
      cr_held_r   <= 1'b0;
      seen_r      <= 1'b0;
      length_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_body_r   <= in_body_nxt;
      phase_r     <= phase_nxt;
      prefix_r    <= prefix_nxt;
      has_chars_r <= has_chars_nxt;
      cr_held_r   <= cr_held_nxt;
      seen_r      <= seen_nxt;
      length_r    <= length_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    body_r   <= body_nxt;
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  // a body never runs with nothing left to pass
  `CLD_ASSERT_ALWAYS(a_body_len_nonzero, !(rst_n && in_body_r && length_r == '0), "body with zero length")
  // once past the name, the whole name must have matched
  `CLD_ASSERT(a_prefix_full, (phase_r == PH_BLANK || phase_r == PH_DIGIT) |-> (prefix_r == NAME_LEN), "length phase without full name")
  // every body transaction yields a result next cycle
  `CLD_ASSERT(a_body_result, (in_fire && in_body_r) |=> (out_valid_r && status_r == STAT_BODY), "body byte lost")
  // status results carry a zero byte, only an empty message is marked last
  `CLD_ASSERT(a_status_payload, (out_valid_r && status_r != STAT_BODY) |-> (body_r == 8'h00 && last_r == (status_r == STAT_EMPTY)), "bad status result payload")
  // a carriage return is never held inside a body
  `CLD_ASSERT(a_no_cr_in_body, in_body_r |-> !cr_held_r, "carriage return held in body")

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for content_length_header_deframer_top: framed byte
// traffic checked against a byte-level copy of the framing rules, with
// header lines, mixed-case names, skipped blanks, saturating digit runs,
// override lines, bare carriage returns, empty messages, blocks with no length,
// random idle gaps on both channels and one long receiver hold-off
// ----------------------------------------------------------------------------
module testbench;
  import cld_pkg::*;

  localparam string NAME_TEXT   = "content-length:";
  localparam int    ITEM_TARGET = 1050;
  localparam int    HOLD_CYCLES = 400;

  typedef struct packed {
    logic [7:0] body;
    status_t    status;
    logic       last;
  } deframe_result_t;

  // ---------------------------------------------------------------------------
  // scoreboard: keeps its own parser state and the queue of pending results
  // ---------------------------------------------------------------------------
  class deframe_scoreboard;
    bit                     in_body;
    phase_t                 phase;
    logic [3:0]             name_pos;
    bit                     line_has_chars;
    bit                     cr_held;
    bit                     length_seen;
    logic [LENGTH_BITS-1:0] body_left;

    deframe_result_t pending_q[$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     body_seen;
    int unsigned     empty_seen;
    int unsigned     no_length_seen;

    function new();
      in_body = 1'b0;
      restart_header();
    endfunction

    task report_mismatch(input string what);
      errors++;
      // keep the log bounded when something goes badly wrong
      if (errors <= 50) $display("mismatch %0d at %0t: %s", errors, $realtime, what);
    endtask

    function int unsigned outstanding();
      return pending_q.size();
    endfunction

    function void restart_line();
      phase          = PH_NAME;
      name_pos       = '0;
      line_has_chars = 1'b0;
    endfunction

    function void restart_header();
      restart_line();
      cr_held     = 1'b0;
      length_seen = 1'b0;
      body_left   = '0;
    endfunction

    function void expect_result(input logic [7:0] body, input status_t st, input logic fin);
      deframe_result_t r;
      r.body   = body;
      r.status = st;
      r.last   = fin;
      pending_q.push_back(r);
    endfunction

    // decimal accumulate, pinned at the top of the length range
    function void push_digit(input logic [7:0] c);
      logic [LENGTH_BITS+3:0] grown;
      grown = ({4'd0, body_left} * (LENGTH_BITS+4)'(10))
              + (LENGTH_BITS+4)'(c - CH_ZERO);
      if (grown > {4'd0, LEN_MAX}) body_left = LEN_MAX;
      else body_left = grown[LENGTH_BITS-1:0];
    endfunction

    function void line_char(input logic [7:0] c);
      logic [7:0] lc;
      bit         digit;
      digit          = (c >= CH_ZERO && c <= CH_NINE);
      line_has_chars = 1'b1;
      case (phase)
        PH_NAME: begin
          lc = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
          if (name_pos < NAME_LEN && lc == NAME_TEXT[name_pos]) begin
            name_pos++;
            if (name_pos == NAME_LEN) begin
              phase       = PH_BLANK;
              length_seen = 1'b1;
              body_left   = '0;
            end
          end else begin
            phase = PH_REST;
          end
        end
        PH_BLANK: begin
          if (c != CH_SP && c != CH_TAB) begin
            if (digit) begin
              phase = PH_DIGIT;
              push_digit(c);
            end else begin
              phase = PH_REST;
            end
          end
        end
        PH_DIGIT: begin
          if (digit) push_digit(c);
          else phase = PH_REST;
        end
        default: ;
      endcase
    endfunction

    // one accepted input byte, zero or one expected result
    function void note_byte(input logic [7:0] b);
      if (in_body) begin
        if (body_left != 0) body_left--;
        expect_result(b, STAT_BODY, body_left == 0);
        if (body_left == 0) begin
          in_body = 1'b0;
          restart_header();
        end
        return;
      end
      if (cr_held) begin
        cr_held = 1'b0;
        if (b == CH_LF) begin
          if (line_has_chars) begin
            restart_line();
          end else if (!length_seen) begin
            restart_header();
            expect_result(8'h00, STAT_NO_LENGTH, 1'b0);
          end else if (body_left == 0) begin
            restart_header();
            expect_result(8'h00, STAT_EMPTY, 1'b1);
          end else begin
            restart_line();
            in_body = 1'b1;
          end
          return;
        end
        // carriage return not followed by line feed counts as a line character
        line_char(CH_CR);
      end
      if (b == CH_CR) cr_held = 1'b1;
      else line_char(b);
    endfunction

    task check_result(input logic [7:0] body, input logic [1:0] st, input logic fin);
      deframe_result_t e;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: byte %02h status %0d last %0b",
                                  body, st, fin));
        return;
      end
      e = pending_q.pop_front();
      checked++;
      case (e.status)
        STAT_BODY:  body_seen++;
        STAT_EMPTY: empty_seen++;
        default:    no_length_seen++;
      endcase
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, wanted %s", st, e.status.name()));
      if (body !== e.body)
        report_mismatch($sformatf("body byte %02h, wanted %02h", body, e.body));
      if (fin !== e.last)
        report_mismatch($sformatf("last flag %0b, wanted %0b", fin, e.last));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // clock, reset, channels and the block itself
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cld_in_if  in_ch ();
  cld_out_if out_ch ();

  content_length_header_deframer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deframe_scoreboard sb = new();

  bit          hold_off = 1'b0;  // receiver held back, sender runs flat out
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int          send_calm = 0;    // bytes left in a stretch with no sender gaps

  // synchronous reset, asserted once at the start of the run
  initial begin
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offers one byte and waits for the transaction; valid stays up when the
  // next byte follows with no gap, so it is never lowered and raised in one step
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    if (send_calm > 0) send_calm--;
    else if ($urandom_range(0, 199) == 0) send_calm = $urandom_range(50, 150);
    gap = (hold_off || send_calm > 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_crlf();
  endtask

  task automatic send_body(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  // a header line that is not a length line; mostly printable, the odd raw byte
  task automatic junk_line();
    repeat ($urandom_range(1, 12)) begin
      if ($urandom_range(0, 9) != 0) send_byte(8'($urandom_range(8'h20, 8'h7e)));
      else send_byte(8'($urandom_range(0, 255)));
    end
    send_crlf();
  endtask

  // content-length line in mixed case; spoil drops one name character, huge
  // writes a digit run far past the length range
  task automatic length_line(input bit spoil, input bit huge, input int value);
    int         cut;
    logic [7:0] c;
    cut = spoil ? $urandom_range(0, 14) : -1;
    for (int k = 0; k < 15; k++) begin
      c = NAME_TEXT[k];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'h20;
      if (k != cut) send_byte(c);
    end
    repeat ($urandom_range(0, 3)) send_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
    if (huge) begin
      send_byte(CH_ZERO + 8'($urandom_range(1, 9)));
      repeat ($urandom_range(10, 19)) send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (value != 0 || $urandom_range(0, 4) != 0) begin
      // leading zeros now and then; a zero may also be left with no digits
      repeat ($urandom_range(0, 2)) send_byte(CH_ZERO);
      send_text($sformatf("%0d", value));
    end
    if ($urandom_range(0, 4) == 0) begin
      send_byte($urandom_range(0, 1) ? 8'h3b : 8'h78);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(8'h20, 8'h7e)));
    end
    send_crlf();
  endtask

  task automatic random_frame();
    int pick;
    int body_len;
    // broken sequence: raw bytes dropped in ahead of the header
    if ($urandom_range(0, 99) < 6) send_body($urandom_range(1, 6));
    repeat ($urandom_range(0, 2)) junk_line();
    pick     = $urandom_range(0, 99);
    body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
    if (pick < 8) begin
      body_len = 0;                       // header block with no length at all
    end else if (pick < 22) begin
      length_line(1'b0, $urandom_range(0, 1), $urandom_range(0, 99));
      length_line(1'b0, 1'b0, body_len);  // the later line wins
    end else if (pick < 27) begin
      length_line(1'b1, 1'b0, body_len);
      body_len = 0;
    end else begin
      length_line(1'b0, 1'b0, body_len);
    end
    repeat ($urandom_range(0, 1)) junk_line();
    send_crlf();
    send_body(body_len);
    frames_sent++;
  endtask

  // drives the stream back to the start of a fresh header block
  task automatic settle_stream();
    int guard;
    guard = 0;
    while (guard < 4000 && (sb.in_body || sb.cr_held || sb.line_has_chars || sb.length_seen)) begin
      if (sb.in_body) send_byte(8'($urandom_range(0, 255)));
      else if (sb.cr_held) send_byte(CH_LF);
      else send_byte(CH_CR);
      guard++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, calm stretches, and the long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    int calm;
    stall = 0;
    calm  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.body_byte, out_ch.status, out_ch.last_of_message);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (calm > 0) calm--;
        else if ($urandom_range(0, 99) < 2) calm = $urandom_range(40, 160);
        else if ($urandom_range(0, 99) < 30) stall = pick_gap();
      end
    end
  end

  // one long hold-off of the result channel, counted here, while the sender
  // keeps offering bytes so the result register fills and the input stalls
  initial begin
    @(posedge clk);
    while (sb.checked < 150) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // generous watchdog for a hung or lost transaction
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.in_byte <= 8'h00;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    repeat (2) @(posedge clk);

    // blank line straight away: header block with no length
    send_crlf();
    // zero length gives one empty-message result
    send_line("Content-Length: 0");
    send_crlf();
    // upper case name, tab and space before digits, body at the byte extremes
    send_line("CONTENT-LENGTH:\t 3");
    send_crlf();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(CH_CR);
    // name with no digits means length zero
    send_line("content-length:");
    send_crlf();
    // bare carriage return ends the digit run, the trailing 2 is ignored
    send_text("content-length: 1");
    send_byte(CH_CR);
    send_line("2");
    send_crlf();
    send_byte(CH_LF);
    // bare carriage return inside the name spoils the match, then a line
    // ending in two carriage returns; no length in the block
    send_text("cont");
    send_byte(CH_CR);
    send_line("ent-length: 4");
    send_text("x");
    send_byte(CH_CR);
    send_crlf();
    send_crlf();
    // later line overrides, leading zeros, junk after digits, lone line feed
    send_line("content-length: 5");
    send_line("Content-length: 000002xyz");
    send_text("host: a");
    send_byte(CH_LF);
    send_crlf();
    send_crlf();
    send_byte(8'h55);
    send_byte(8'haa);
    // overlong length saturates, then gets overridden
    send_line("content-length: 99999999999");
    send_line("cOnTeNt-LeNgTh:1");
    send_crlf();
    send_byte(8'h7f);
    frames_sent += 8;

    while (bytes_sent < ITEM_TARGET) random_frame();

    // finish with a saturated length: a counter that wraps would see a length
    // of one and mark the first body byte as last
    settle_stream();
    send_line("Content-Length: 4294967297");
    send_crlf();
    send_body(12);
    frames_sent++;
    in_ch.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d bytes in %0d frames with idle gaps and one long hold-off",
             bytes_sent, frames_sent);
    $display("checked %0d results: %0d body bytes, %0d empty, %0d without length",
             sb.checked, sb.body_seen, sb.empty_seen, sb.no_length_seen);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cld_pkg.sv
rtl/cld_in_if.sv
rtl/cld_out_if.sv
rtl/content_length_header_deframer_top.sv
tb/testbench.sv
